// ===== src/ray_reflect_refract_unit_assert.svh =====
// Assertion macros for the ray reflect/refract unit checker.
`ifndef RAY_REFLECT_REFRACT_UNIT_ASSERT_SVH
`define RAY_REFLECT_REFRACT_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define RRU_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define RRU_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== src/rru_pkg.sv =====
// Shared types and constants for the ray reflect/refract unit.
`default_nettype none
package rru_pkg;
   localparam int FRAC = 12;
   localparam int CW = 16;
   localparam logic CMD_REFLECT = 1'b0;
   localparam logic CMD_REFRACT = 1'b1;

   typedef struct packed {
      logic               command;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic [14:0]        eta_ratio;
   } req_type;

   typedef struct packed {
      logic signed [15:0] out_x;
      logic signed [15:0] out_y;
      logic signed [15:0] out_z;
      logic               saturated;
   } rsp_type;

   typedef logic signed [15:0] vec_type [3];
endpackage
`default_nettype wire

// ===== src/rru_sqrt_stage.sv =====
// One two-bit step of a pipelined floor square root.
`default_nettype none
module rru_sqrt_stage import rru_pkg::*; #(
   parameter int STEP = 0
) (
   input  wire logic        clock,
   input  wire logic        enable,
   input  wire logic [25:0] rem_in,
   input  wire logic [12:0] root_in,
   output logic      [25:0] rem_out,
   output logic      [12:0] root_out
);
   localparam int SH = 24 - 2 * STEP;
   logic [27:0] trial;
   logic [27:0] part;
   logic [25:0] rem_in_c;
   logic [12:0] root_in_c;
   always_comb begin
      part  = 28'(rem_in >> SH);
      trial = {13'd0, root_in, 2'b01};
      if (part >= trial) begin
         rem_in_c  = rem_in - 26'(trial << SH);
         root_in_c = {root_in[11:0], 1'b1};
      end else begin
         rem_in_c  = rem_in;
         root_in_c = {root_in[11:0], 1'b0};
      end
   end
   always_ff @(posedge clock) begin
      if (enable) begin
         rem_out  <= rem_in_c;
         root_out <= root_in_c;
      end
   end
endmodule
`default_nettype wire

// ===== src/ray_reflect_refract_unit.sv =====
// Ray reflect/refract unit: top level with the arithmetic pipeline.
// Usage:
//  req_ channel carries one item (command, direction, normal, eta ratio);
//  rsp_ channel returns one result item per request item, in order.
//  Command reflect gives d - 2(d.n)n; refract gives Snell refraction.
//  21 register stages: products, dot sum and cosine, n*k, d + n*k,
//  eta multiply, |par|^2 terms, radicand, thirteen square-root steps
//  (one root bit each), then the final multiply-add and saturation.
//  With no stall rsp_valid rises when the item reaches the last stage.
//  Throughput is one item per cycle while rsp_stall is low.
//  When rsp_stall is high a full last stage holds; stages behind it
//  keep moving until they close up on it (bubbles are squeezed).
//  req_stall rises only when every stage holds an item, so nothing is
//  lost or repeated.
//  Synchronous reset clears all valid bits; payload registers keep data.
`default_nettype none
module ray_reflect_refract_unit import rru_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);
   localparam int NS = 21;
   localparam int SQ = 13;
   logic [NS-1:0] v_ff, v_in;
   logic [NS-1:0] en;

   // stage enables: a stage loads when it is empty or the next one moves
   always_comb begin
      en[NS-1] = !v_ff[NS-1] || !rsp_stall;
      for (int i = NS - 2; i >= 0; i--) en[i] = !v_ff[i] || en[i+1];
      for (int i = 1; i < NS; i++) v_in[i] = en[i] ? v_ff[i-1] : v_ff[i];
      if (en[0]) v_in[0] = req_valid; else v_in[0] = v_ff[0];
   end
   assign req_stall = !en[0];
   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else begin
         for (int i = 0; i < NS; i++) v_ff[i] <= v_in[i];
      end
   end

   function automatic logic signed [47:0] fl(input logic signed [47:0] p);
      return p >>> FRAC;
   endfunction

   // s0: capture and products d*n
   logic cmd0_ff; logic signed [16:0] d0_ff [3]; logic signed [16:0] n0_ff [3];
   logic [14:0] e0_ff; logic signed [33:0] pr0_ff [3];
   always_ff @(posedge clock) if (en[0]) begin
      cmd0_ff <= req_data.command; e0_ff <= req_data.eta_ratio;
      d0_ff[0] <= req_data.dir_x; d0_ff[1] <= req_data.dir_y; d0_ff[2] <= req_data.dir_z;
      n0_ff[0] <= req_data.normal_x; n0_ff[1] <= req_data.normal_y;
      n0_ff[2] <= req_data.normal_z;
      pr0_ff[0] <= 34'(req_data.dir_x * req_data.normal_x);
      pr0_ff[1] <= 34'(req_data.dir_y * req_data.normal_y);
      pr0_ff[2] <= 34'(req_data.dir_z * req_data.normal_z);
   end
   // s1: dot sum; k = 2dot (reflect, subtracted later) or min(-dot,1) (refract)
   logic cmd1_ff; logic signed [16:0] d1_ff [3]; logic signed [16:0] n1_ff [3];
   logic [14:0] e1_ff; logic signed [23:0] k1_ff;
   logic signed [23:0] dot1;
   always_comb begin
      dot1 = 24'(fl(48'(pr0_ff[0])) + fl(48'(pr0_ff[1])) + fl(48'(pr0_ff[2])));
   end
   always_ff @(posedge clock) if (en[1]) begin
      cmd1_ff <= cmd0_ff; d1_ff <= d0_ff; n1_ff <= n0_ff; e1_ff <= e0_ff;
      if (cmd0_ff == CMD_REFLECT) k1_ff <= dot1 <<< 1;
      else k1_ff <= (-dot1 > 24'sd4096) ? 24'sd4096 : -dot1;
   end
   // s2: n*k
   logic cmd2_ff; logic signed [16:0] d2_ff [3]; logic signed [16:0] n2_ff [3];
   logic [14:0] e2_ff; logic signed [40:0] m2_ff [3];
   always_ff @(posedge clock) if (en[2]) begin
      cmd2_ff <= cmd1_ff; d2_ff <= d1_ff; n2_ff <= n1_ff; e2_ff <= e1_ff;
      for (int i = 0; i < 3; i++) m2_ff[i] <= 41'(n1_ff[i] * k1_ff);
   end
   // s3: reflect d - floor(n*k), refract d + floor(n*k)
   logic cmd3_ff; logic signed [16:0] n3_ff [3]; logic [14:0] e3_ff;
   logic signed [29:0] a3_ff [3];
   always_ff @(posedge clock) if (en[3]) begin
      cmd3_ff <= cmd2_ff; n3_ff <= n2_ff; e3_ff <= e2_ff;
      for (int i = 0; i < 3; i++) begin
         if (cmd2_ff == CMD_REFLECT) a3_ff[i] <= 30'(d2_ff[i] - fl(48'(m2_ff[i])));
         else a3_ff[i] <= 30'(d2_ff[i] + fl(48'(m2_ff[i])));
      end
   end
   // s4: product a*eta (floored to par in s5)
   logic cmd4_ff; logic signed [16:0] n4_ff [3];
   logic signed [29:0] a4_ff [3]; logic signed [45:0] p4_ff [3];
   always_ff @(posedge clock) if (en[4]) begin
      cmd4_ff <= cmd3_ff; n4_ff <= n3_ff; a4_ff <= a3_ff;
      for (int i = 0; i < 3; i++) p4_ff[i] <= 46'(a3_ff[i] * $signed({1'b0, e3_ff}));
   end
   // s5: floor par, big test, squares
   logic cmd5_ff; logic signed [16:0] n5_ff [3]; logic signed [33:0] par5_ff [3];
   logic signed [29:0] a5_ff [3]; logic big5_ff; logic [25:0] sqp5_ff [3];
   logic signed [33:0] par5 [3]; logic big5;
   always_comb begin
      big5 = 1'b0;
      for (int i = 0; i < 3; i++) begin
         par5[i] = 34'(fl(48'(p4_ff[i])));
         if (par5[i] > 34'sd4096 || par5[i] < -34'sd4096) big5 = 1'b1;
      end
   end
   always_ff @(posedge clock) if (en[5]) begin
      cmd5_ff <= cmd4_ff; n5_ff <= n4_ff; a5_ff <= a4_ff; par5_ff <= par5; big5_ff <= big5;
      // squares only matter when |par| <= 1.0, which fits 14 signed bits
      for (int i = 0; i < 3; i++)
         sqp5_ff[i] <= 26'($signed(par5[i][13:0]) * $signed(par5[i][13:0]));
   end
   // s6: |par|^2 and radicand
   logic cmd6_ff; logic signed [16:0] n6_ff [3]; logic signed [33:0] par6_ff [3];
   logic signed [29:0] a6_ff [3]; logic [25:0] rad6_ff;
   logic [15:0] sq6;
   always_comb begin
      sq6 = 16'(sqp5_ff[0] >> FRAC) + 16'(sqp5_ff[1] >> FRAC) + 16'(sqp5_ff[2] >> FRAC);
      if (big5_ff || sq6 > 16'd4096) sq6 = 16'd4096;
   end
   always_ff @(posedge clock) if (en[6]) begin
      cmd6_ff <= cmd5_ff; n6_ff <= n5_ff; par6_ff <= par5_ff; a6_ff <= a5_ff;
      rad6_ff <= 26'(16'd4096 - sq6) << FRAC;
   end
   // s7..s19: square root, one bit per stage
   logic [25:0] rem_w [SQ+1]; logic [12:0] root_w [SQ+1];
   logic cmdq_ff [SQ]; logic signed [16:0] nq_ff [SQ][3];
   logic signed [33:0] parq_ff [SQ][3]; logic signed [29:0] aq_ff [SQ][3];
   assign rem_w[0] = rad6_ff; assign root_w[0] = '0;
   for (genvar g = 0; g < SQ; g++) begin : g_sq
      rru_sqrt_stage #(.STEP(g)) u_st (
         .clock(clock), .enable(en[7+g]), .rem_in(rem_w[g]), .root_in(root_w[g]),
         .rem_out(rem_w[g+1]), .root_out(root_w[g+1]));
   end
   always_ff @(posedge clock) begin
      for (int g = 0; g < SQ; g++) begin
         if (en[7+g]) begin
            if (g == 0) begin
               cmdq_ff[0] <= cmd6_ff; nq_ff[0] <= n6_ff;
               parq_ff[0] <= par6_ff; aq_ff[0] <= a6_ff;
            end else begin
               cmdq_ff[g] <= cmdq_ff[g-1]; nq_ff[g] <= nq_ff[g-1];
               parq_ff[g] <= parq_ff[g-1]; aq_ff[g] <= aq_ff[g-1];
            end
         end
      end
   end
   // s20: final combine and saturation
   logic signed [47:0] r20 [3]; logic sat20; logic signed [15:0] o20 [3];
   always_comb begin
      sat20 = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (cmdq_ff[SQ-1] == CMD_REFLECT)
            r20[i] = 48'(aq_ff[SQ-1][i]);
         else
            r20[i] = 48'(parq_ff[SQ-1][i])
                   + fl(48'(nq_ff[SQ-1][i] * -$signed({1'b0, root_w[SQ]})));
         if (r20[i] > 48'sd32767) begin o20[i] = 16'sh7fff; sat20 = 1'b1; end
         else if (r20[i] < -48'sd32768) begin o20[i] = 16'sh8000; sat20 = 1'b1; end
         else o20[i] = 16'(r20[i]);
      end
   end
   always_ff @(posedge clock) if (en[20]) begin
      rsp_data.out_x <= o20[0]; rsp_data.out_y <= o20[1]; rsp_data.out_z <= o20[2];
      rsp_data.saturated <= sat20;
   end
   assign rsp_valid = v_ff[NS-1];
endmodule
`default_nettype wire

// ===== src/rru_checker.sv =====
// Port-level checker for the ray reflect/refract unit, with its bind.
`default_nettype none
`include "ray_reflect_refract_unit_assert.svh"
module rru_checker import rru_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);
   `RRU_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `RRU_ASSERT_NXT(a_rsp_data, clock, reset, rsp_valid && rsp_stall, $stable(rsp_data))
   `RRU_ASSERT_IMP(a_no_stall_free, clock, reset, !rsp_valid, !req_stall)
   `RRU_ASSERT_IMP(a_stall_cause, clock, reset, req_stall, rsp_stall)
endmodule
bind ray_reflect_refract_unit rru_checker u_chk (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data));
`default_nettype wire

// ===== verif/tb_top.sv =====
// Testbench for the ray reflect/refract unit: directed table plus random items.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   import rru_pkg::*;

   localparam int ONE = 4096;
   localparam int WATCHDOG = 5000;
   localparam int N_RANDOM = 630;
   localparam int DRAIN = 60;

   typedef struct {
      req_type req;
      logic    known;
      rsp_type rsp;
   } table_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   rsp_type        bounce_queue[$];
   int             fail_count = 0;
   int             idle_cycles = 0;
   table_row_type  dir_table[$];

   ray_reflect_refract_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint fx_mul(longint a, longint b);
      return (a * b) >>> 12;
   endfunction

   function automatic longint isqrt64(longint v);
      longint res, bit_w;
      res = 0;
      bit_w = longint'(1) << 60;
      while (bit_w > v) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (v >= res + bit_w) begin
            v = v - (res + bit_w);
            res = (res >> 1) + bit_w;
         end else begin
            res = res >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return res;
   endfunction

   function automatic rsp_type predict_bounce(req_type q);
      longint d[3], n[3], r[3], par[3];
      longint dotv, cosv, sq, root, eta;
      logic   big, sat;
      rsp_type o;
      d[0] = q.dir_x; d[1] = q.dir_y; d[2] = q.dir_z;
      n[0] = q.normal_x; n[1] = q.normal_y; n[2] = q.normal_z;
      eta = longint'(q.eta_ratio);
      dotv = fx_mul(d[0], n[0]) + fx_mul(d[1], n[1]) + fx_mul(d[2], n[2]);
      sat = 1'b0;
      big = 1'b0;
      sq = 0;
      if (q.command == CMD_REFLECT) begin
         for (int i = 0; i < 3; i++) r[i] = d[i] - fx_mul(n[i], 2 * dotv);
      end else begin
         cosv = -dotv;
         if (cosv > ONE) cosv = ONE;
         for (int i = 0; i < 3; i++) begin
            par[i] = fx_mul(d[i] + fx_mul(n[i], cosv), eta);
            if (par[i] > ONE || par[i] < -ONE) big = 1'b1;
         end
         if (big) begin
            sq = ONE;
         end else begin
            for (int i = 0; i < 3; i++) sq += fx_mul(par[i], par[i]);
            if (sq > ONE) sq = ONE;
         end
         root = isqrt64((ONE - sq) << 12);
         for (int i = 0; i < 3; i++) r[i] = par[i] + fx_mul(n[i], -root);
      end
      for (int i = 0; i < 3; i++) begin
         if (r[i] > 32767) begin r[i] = 32767; sat = 1'b1; end
         if (r[i] < -32768) begin r[i] = -32768; sat = 1'b1; end
      end
      o.out_x = r[0][15:0];
      o.out_y = r[1][15:0];
      o.out_z = r[2][15:0];
      o.saturated = sat;
      return o;
   endfunction

   function automatic req_type mk_req(logic cmd, int dx, int dy, int dz,
                                      int nx, int ny, int nz, int eta);
      req_type q;
      q.command = cmd;
      q.dir_x = dx[15:0]; q.dir_y = dy[15:0]; q.dir_z = dz[15:0];
      q.normal_x = nx[15:0]; q.normal_y = ny[15:0]; q.normal_z = nz[15:0];
      q.eta_ratio = eta[14:0];
      return q;
   endfunction

   function automatic rsp_type mk_rsp(int x, int y, int z, logic s);
      rsp_type o;
      o.out_x = x[15:0]; o.out_y = y[15:0]; o.out_z = z[15:0]; o.saturated = s;
      return o;
   endfunction

   task automatic add_row(req_type q, logic known, rsp_type o);
      table_row_type t;
      t.req = q; t.known = known; t.rsp = o;
      dir_table.push_back(t);
   endtask

   function automatic req_type random_req();
      req_type q;
      int unit_mode;
      q = req_type'(112'({$urandom, $urandom, $urandom, $urandom}));
      unit_mode = $urandom_range(0, 3);
      // mostly unit-scale vectors so refraction reaches the sqrt path
      if (unit_mode != 0) begin
         q.dir_x = 16'($signed($urandom_range(0, 2 * ONE)) - ONE);
         q.dir_y = 16'($signed($urandom_range(0, 2 * ONE)) - ONE);
         q.dir_z = 16'($signed($urandom_range(0, 2 * ONE)) - ONE);
         q.normal_x = 16'($signed($urandom_range(0, 2 * ONE)) - ONE);
         q.normal_y = 16'($signed($urandom_range(0, 2 * ONE)) - ONE);
         q.normal_z = 16'($signed($urandom_range(0, 2 * ONE)) - ONE);
         q.eta_ratio = 15'($urandom_range(0, 2 * ONE));
      end
      return q;
   endfunction

   // valid stays high into the next item when the drawn gap is zero
   task automatic send_item(req_type q);
      int gap;
      gap = $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bounce_queue.push_back(predict_bounce(q));
      @(negedge clock);
   endtask

   // sender
   initial begin
      rsp_type z;
      z = '0;
      // reflect
      add_row(mk_req(CMD_REFLECT, 0, 0, 0, 0, 0, 0, 0), 1'b1, mk_rsp(0, 0, 0, 1'b0));
      add_row(mk_req(CMD_REFLECT, 0, -ONE, 0, 0, ONE, 0, 0), 1'b1,
              mk_rsp(0, ONE, 0, 1'b0));
      add_row(mk_req(CMD_REFLECT, ONE, 0, 0, 0, ONE, 0, 32767), 1'b1,
              mk_rsp(ONE, 0, 0, 1'b0));
      add_row(mk_req(CMD_REFLECT, 32767, 32767, 32767, 32767, 32767, 32767, 0),
              1'b1, mk_rsp(-32768, -32768, -32768, 1'b1));
      add_row(mk_req(CMD_REFLECT, -32768, -32768, -32768, -32768, -32768, -32768, 0),
              1'b0, z);
      add_row(mk_req(CMD_REFLECT, -32768, 32767, -32768, 32767, -32768, 32767, 0),
              1'b0, z);
      // refract
      add_row(mk_req(CMD_REFRACT, 0, -ONE, 0, 0, ONE, 0, ONE), 1'b1,
              mk_rsp(0, -ONE, 0, 1'b0));
      add_row(mk_req(CMD_REFRACT, 0, 0, 0, 0, 0, 0, 0), 1'b1, mk_rsp(0, 0, 0, 1'b0));
      add_row(mk_req(CMD_REFRACT, 2896, -2896, 0, 0, ONE, 0, ONE), 1'b0, z);
      add_row(mk_req(CMD_REFRACT, 2896, -2896, 0, 0, ONE, 0, 6000), 1'b0, z);
      add_row(mk_req(CMD_REFRACT, 2896, -2896, 0, 0, ONE, 0, 32767), 1'b0, z);
      add_row(mk_req(CMD_REFRACT, ONE, ONE, 0, 0, ONE, 0, 2048), 1'b0, z);
      add_row(mk_req(CMD_REFRACT, 32767, 32767, 32767, 32767, 32767, 32767, 32767),
              1'b0, z);
      add_row(mk_req(CMD_REFRACT, -32768, -32768, -32768, -32768, -32768, -32768,
                     32767), 1'b0, z);
      add_row(mk_req(CMD_REFRACT, -32768, 0, 32767, 32767, 0, -32768, 1), 1'b0, z);
      add_row(mk_req(CMD_REFRACT, ONE, 0, 0, ONE, 0, 0, ONE), 1'b0, z);
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (dir_table[i]) begin
         send_item(dir_table[i].req);
         // typed-in value must agree with the predictor
         if (dir_table[i].known && bounce_queue[$] !== dir_table[i].rsp) begin
            $display("%0t row %0d expected %h actual %h", $time, i,
                     dir_table[i].rsp, bounce_queue[$]);
            fail_count++;
         end
      end
      for (int k = 0; k < N_RANDOM; k++) begin
         if (k == N_RANDOM / 2) begin
            req_valid <= 1'b0;
            @(negedge clock);
            while (bounce_queue.size() != 0) @(negedge clock);
         end
         send_item(random_req());
      end
      req_valid <= 1'b0;
      while (bounce_queue.size() != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // receiver stall pattern, with quiet stretches
   initial begin
      int quiet;
      int hold;
      quiet = 0;
      forever begin
         @(negedge clock);
         if (quiet > 0) begin
            quiet--;
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 19) == 0) begin
            quiet = $urandom_range(20, 60);
            rsp_stall <= 1'b0;
         end else begin
            hold = $urandom_range(0, 14);
            if (hold > 0) begin
               rsp_stall <= 1'b1;
               repeat (hold) @(negedge clock);
            end
            rsp_stall <= 1'b0;
            @(posedge clock);
            while (!(rsp_valid && !rsp_stall)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (bounce_queue.size() == 0) begin
            $display("%0t unexpected item expected none actual %h", $time, rsp_data);
            fail_count++;
         end else begin
            if (rsp_data.out_x !== bounce_queue[0].out_x) begin
               $display("%0t out_x expected %h actual %h", $time,
                        bounce_queue[0].out_x, rsp_data.out_x);
               fail_count++;
            end
            if (rsp_data.out_y !== bounce_queue[0].out_y) begin
               $display("%0t out_y expected %h actual %h", $time,
                        bounce_queue[0].out_y, rsp_data.out_y);
               fail_count++;
            end
            if (rsp_data.out_z !== bounce_queue[0].out_z) begin
               $display("%0t out_z expected %h actual %h", $time,
                        bounce_queue[0].out_z, rsp_data.out_z);
               fail_count++;
            end
            if (rsp_data.saturated !== bounce_queue[0].saturated) begin
               $display("%0t saturated expected %b actual %b", $time,
                        bounce_queue[0].saturated, rsp_data.saturated);
               fail_count++;
            end
            void'(bounce_queue.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("FAILURE");
         $finish;
      end
   end
endmodule
`default_nettype wire
